/* rtl/bwds_pkg.sv */
// Shared constants and types for the binary window disparity search block.
// No dependencies.
`default_nettype none

package bwds_pkg;

  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 1024;
  localparam int MAX_HALF_D   = 7;
  localparam int MAX_DISP_D   = 64;

  localparam int CFG_DW = 11;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;
  localparam logic [1:0] REG_DISP   = 2'd3;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [10:0] RST_HEIGHT = 11'd480;
  localparam logic [2:0]  RST_HALF   = 3'd2;
  localparam logic [6:0]  RST_DISP   = 7'd64;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/bwds_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bwds_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/binary_window_disparity_search.sv */
// Binary stereo disparity search, top level.
// Depends on bwds_pkg and bwds_ram.
//
// Pixel pairs come in raster order and are kept in two ring line memories of
// 2*MAX_HALF+2 rows. After each pixel transfer (or flush transfer once the
// frame is complete) the next result is emitted if its window has arrived.
// A result reads every window bit for every shift, one per cycle, through
// the single read port of each line memory. A pixel transfer, or a flush
// transfer while a frame is draining, that yields no result passes through
// the evaluation state only; other flush transfers do not leave idle. Input
// is taken only while no result is being computed; a finished result waits in
// the output register while the next transfer is taken.
`default_nettype none

module binary_window_disparity_search #(
  parameter int MAX_WIDTH  = bwds_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = bwds_pkg::MAX_HEIGHT_D,
  parameter int MAX_HALF   = bwds_pkg::MAX_HALF_D,
  parameter int MAX_DISP   = bwds_pkg::MAX_DISP_D
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        mode,
  input  wire logic        left_bit,
  input  wire logic        right_bit,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [5:0]  disparity,
  output      logic [7:0]  best_cost,
  output      logic [9:0]  out_row,
  output      logic [9:0]  out_col,
  output      logic        last_of_frame
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HTW   = $clog2(MAX_HEIGHT + 1);
  localparam int HHW   = $clog2(MAX_HALF + 1);
  localparam int SW    = HHW + 1;
  localparam int KW    = (MAX_DISP > 1) ? $clog2(MAX_DISP) : 1;
  localparam int DW    = $clog2(MAX_DISP + 1);
  localparam int RING  = 2 * MAX_HALF + 2;
  localparam int RGW   = $clog2(RING);
  localparam int RS    = RGW + 2;
  localparam int DEPTH = RING * (2 ** CW);
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH + MAX_HALF + MAX_DISP) + 1;
  localparam int YW    = $clog2(MAX_HEIGHT + MAX_HALF) + 1;
  localparam int BW    = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);

  // configuration
  logic [10:0] cfg_width, cfg_height;
  logic [2:0]  cfg_half;
  logic [6:0]  cfg_disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= bwds_pkg::RST_WIDTH;
      cfg_height <= bwds_pkg::RST_HEIGHT;
      cfg_half   <= bwds_pkg::RST_HALF;
      cfg_disp   <= bwds_pkg::RST_DISP;
    end else if (cfg_we) begin
      case (cfg_addr)
        bwds_pkg::REG_WIDTH:  cfg_width  <= cfg_data;
        bwds_pkg::REG_HEIGHT: cfg_height <= cfg_data;
        bwds_pkg::REG_HALF:   cfg_half   <= cfg_data[2:0];
        bwds_pkg::REG_DISP:   cfg_disp   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0]      w_eff;
  logic [HTW-1:0]     hgt_eff;
  logic [HHW-1:0]     h_eff;
  logic [DW-1:0]      d_eff;
  logic [HHW:0]       side;
  logic [2*HHW+1:0]   side_sq;
  logic [BW-1:0]      area;

  always_comb begin
    if (cfg_width == 11'd0) w_eff = WW'(1);
    else if (cfg_width > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_width);
    if (cfg_height == 11'd0) hgt_eff = HTW'(1);
    else if (cfg_height > MAX_HEIGHT) hgt_eff = HTW'(MAX_HEIGHT);
    else hgt_eff = HTW'(cfg_height);
    if (cfg_half == 3'd0) h_eff = HHW'(1);
    else if (cfg_half > MAX_HALF) h_eff = HHW'(MAX_HALF);
    else h_eff = HHW'(cfg_half);
    if (cfg_disp == 7'd0) d_eff = DW'(1);
    else if (cfg_disp > MAX_DISP) d_eff = DW'(MAX_DISP);
    else d_eff = DW'(cfg_disp);
  end

  assign side    = {h_eff, 1'b1};
  assign side_sq = side * side;
  assign area    = BW'(side_sq);

  // state
  bwds_pkg::state_t state, state_next;

  logic [RW-1:0]  in_row, in_row_next, res_row, res_row_next;
  logic [CW-1:0]  in_col, in_col_next, res_col, res_col_next;
  logic [RGW-1:0] in_ring, in_ring_next, res_ring, res_ring_next;
  logic           tail, tail_next;

  logic [KW-1:0]        k_cnt;
  logic signed [SW-1:0] dy, dx, h_s;
  logic                 iss_on;
  logic                 dv, dloob, droob, dendk, dlast;
  logic [KW-1:0]        dk;
  logic [BW-1:0]        cost_acc, best, tot;
  logic [KW-1:0]        dis;

  logic pix_xfer, flush_xfer, out_free, out_load, mem_we;
  logic res_oob, not_ready, iss_endk, iss_last;

  assign pix_xfer   = in_valid && in_ready && (mode == bwds_pkg::MODE_PIXEL);
  assign flush_xfer = in_valid && in_ready && (mode == bwds_pkg::MODE_FLUSH);
  assign out_free   = !out_valid || out_ready;
  assign h_s        = $signed({1'b0, h_eff});

  // pixel write position
  logic [RW-1:0]  p_irow;
  logic [CW-1:0]  p_icol;
  logic [RGW-1:0] p_iring;
  logic           clr_res;
  logic [CW:0]    col_inc;
  logic [RW:0]    row_inc;
  logic [AW-1:0]  wr_addr;

  always_comb begin
    p_irow  = in_row;
    p_icol  = in_col;
    p_iring = in_ring;
    clr_res = tail;
    if (in_row >= hgt_eff || in_col >= w_eff) begin
      p_irow  = '0;
      p_icol  = '0;
      p_iring = '0;
      clr_res = 1'b1;
    end
    col_inc = {1'b0, p_icol} + 1'b1;
    row_inc = {1'b0, p_irow} + 1'b1;
    wr_addr = {p_iring, p_icol};
  end

  // readiness of the pending result
  logic [RW:0]    nr;
  logic [XW-1:0]  nc;

  always_comb begin
    nr = {1'b0, res_row} + (RW+1)'(h_eff);
    if (nr > hgt_eff - 1'b1) nr = (RW+1)'(hgt_eff - 1'b1);
    nc = XW'(res_col) + XW'(h_eff) + XW'(d_eff) - 1'b1;
    if (nc > XW'(w_eff) - 1'b1) nc = XW'(w_eff) - 1'b1;
    res_oob   = (res_row >= hgt_eff) || (res_col >= w_eff);
    not_ready = !tail && ((nr > (RW+1)'(in_row)) ||
                ((nr == (RW+1)'(in_row)) && (nc >= XW'(in_col))));
  end

  // window read addressing
  logic signed [YW-1:0] ly;
  logic signed [XW-1:0] lx, rx;
  logic signed [RS-1:0] rr;
  logic                 row_oob, loob, roob;
  logic [AW-1:0]        rd_addr_l, rd_addr_r;
  logic                 lq, rq, mism;

  always_comb begin
    ly      = $signed(YW'(res_row)) + YW'(dy);
    lx      = $signed(XW'(res_col)) + XW'(dx);
    rx      = lx + $signed(XW'(k_cnt));
    row_oob = (ly < 0) || (ly >= $signed(YW'(hgt_eff)));
    loob    = row_oob || (lx < 0) || (lx >= $signed(XW'(w_eff)));
    roob    = row_oob || (rx < 0) || (rx >= $signed(XW'(w_eff)));
    rr      = $signed(RS'(res_ring)) + RS'(dy);
    if (rr < 0) rr = rr + RS'(RING);
    else if (rr >= $signed(RS'(RING))) rr = rr - RS'(RING);
    rd_addr_l = {rr[RGW-1:0], lx[CW-1:0]};
    rd_addr_r = {rr[RGW-1:0], rx[CW-1:0]};
    iss_endk  = (dx == h_s) && (dy == h_s);
    iss_last  = iss_endk && ((DW'(k_cnt) + 1'b1) == d_eff);
    mism      = (dloob ? 1'b0 : lq) ^ (droob ? 1'b0 : rq);
    tot       = cost_acc + BW'(mism);
  end

  bwds_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (left_bit),
    .raddr (rd_addr_l),
    .rdata (lq)
  );

  bwds_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (right_bit),
    .raddr (rd_addr_r),
    .rdata (rq)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bwds_pkg::ST_IDLE: begin
        if (pix_xfer || (flush_xfer && tail)) state_next = bwds_pkg::ST_EVAL;
      end
      bwds_pkg::ST_EVAL: begin
        if (res_oob || not_ready) state_next = bwds_pkg::ST_IDLE;
        else state_next = bwds_pkg::ST_RUN;
      end
      bwds_pkg::ST_RUN: begin
        if (dv && dlast) state_next = bwds_pkg::ST_DONE;
      end
      bwds_pkg::ST_DONE: begin
        if (out_free) state_next = bwds_pkg::ST_IDLE;
      end
      default: state_next = bwds_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state)
      bwds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_valid && (mode == bwds_pkg::MODE_PIXEL);
      end
      bwds_pkg::ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // position counters
  always_comb begin
    in_row_next   = in_row;
    in_col_next   = in_col;
    in_ring_next  = in_ring;
    res_row_next  = res_row;
    res_col_next  = res_col;
    res_ring_next = res_ring;
    tail_next     = tail;
    if (pix_xfer) begin
      if (clr_res) begin
        res_row_next  = '0;
        res_col_next  = '0;
        res_ring_next = '0;
      end
      tail_next    = 1'b0;
      in_row_next  = p_irow;
      in_ring_next = p_iring;
      in_col_next  = col_inc[CW-1:0];
      if (col_inc == (CW+1)'(w_eff)) begin
        in_col_next = '0;
        in_row_next = row_inc[RW-1:0];
        in_ring_next = (p_iring == RGW'(RING - 1)) ? '0 : p_iring + 1'b1;
        if (row_inc == (RW+1)'(hgt_eff)) begin
          in_row_next  = '0;
          in_ring_next = '0;
          tail_next    = 1'b1;
        end
      end
    end else if (state == bwds_pkg::ST_EVAL && res_oob) begin
      tail_next     = 1'b0;
      res_row_next  = '0;
      res_col_next  = '0;
      res_ring_next = '0;
    end else if (out_load) begin
      res_col_next = res_col + 1'b1;
      if (({1'b0, res_col} + 1'b1) == (CW+1)'(w_eff)) begin
        res_col_next  = '0;
        res_row_next  = res_row + 1'b1;
        res_ring_next = (res_ring == RGW'(RING - 1)) ? '0 : res_ring + 1'b1;
        if (({1'b0, res_row} + 1'b1) == (RW+1)'(hgt_eff)) begin
          res_row_next  = '0;
          res_ring_next = '0;
          tail_next     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bwds_pkg::ST_IDLE;
      in_row   <= '0;
      in_col   <= '0;
      in_ring  <= '0;
      res_row  <= '0;
      res_col  <= '0;
      res_ring <= '0;
      tail     <= 1'b0;
      iss_on   <= 1'b0;
      dv       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_ring  <= in_ring_next;
      res_row  <= res_row_next;
      res_col  <= res_col_next;
      res_ring <= res_ring_next;
      tail     <= tail_next;
      dv       <= (state == bwds_pkg::ST_RUN) && iss_on;
      if (state == bwds_pkg::ST_EVAL) iss_on <= 1'b1;
      else if (state == bwds_pkg::ST_RUN && iss_last) iss_on <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // window sweep and cost accumulation
  always_ff @(posedge clk) begin
    dloob <= loob;
    droob <= roob;
    dendk <= iss_endk;
    dlast <= iss_last;
    dk    <= k_cnt;
    if (state == bwds_pkg::ST_EVAL) begin
      k_cnt    <= '0;
      dy       <= -h_s;
      dx       <= -h_s;
      cost_acc <= '0;
      best     <= area;
      dis      <= '0;
    end else begin
      if (state == bwds_pkg::ST_RUN && iss_on) begin
        if (dx == h_s) begin
          dx <= -h_s;
          if (dy == h_s) begin
            dy    <= -h_s;
            k_cnt <= k_cnt + 1'b1;
          end else begin
            dy <= dy + 1'b1;
          end
        end else begin
          dx <= dx + 1'b1;
        end
      end
      if (dv) begin
        if (dendk) begin
          cost_acc <= '0;
          if (tot < best) begin
            best <= tot;
            dis  <= dk;
          end
        end else begin
          cost_acc <= tot;
        end
      end
    end
    if (out_load) begin
      disparity     <= 6'(dis);
      best_cost     <= 8'(best);
      out_row       <= 10'(res_row);
      out_col       <= 10'(res_col);
      last_of_frame <= (({1'b0, res_row} + 1'b1) == (RW+1)'(hgt_eff)) &&
                       (({1'b0, res_col} + 1'b1) == (CW+1)'(w_eff));
    end
  end

  a_data_in_run: assert property (@(posedge clk) disable iff (rst)
    dv |-> state == bwds_pkg::ST_RUN)
    else $error("window data returned outside the sweep");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    state == bwds_pkg::ST_DONE |-> best <= area)
    else $error("best cost above window area");

  a_dis_bound: assert property (@(posedge clk) disable iff (rst)
    state == bwds_pkg::ST_DONE |-> DW'(dis) < d_eff)
    else $error("disparity outside tested shifts");

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (res_ring < RGW'(RING - 1) || res_ring == RGW'(RING - 1)) &&
    (in_ring < RGW'(RING - 1) || in_ring == RGW'(RING - 1)))
    else $error("ring row pointer out of range");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state == bwds_pkg::ST_RUN) |-> !mem_we)
    else $error("line memory written during sweep");

endmodule

`default_nettype wire

/* tb/tb_binary_window_disparity_search.sv */
`timescale 1ns / 100ps
// Testbench for binary_window_disparity_search: directed table, then random frames,
// every result checked against an in-bench predictor or typed value. Depends on bwds_pkg.
module tb_binary_window_disparity_search;

  localparam int RING = 2 * bwds_pkg::MAX_HALF_D + 2;
  localparam int STALL_LIMIT = 100000;
  localparam int ITEMS = 1650;

  typedef struct packed {
    logic [5:0] disp;
    logic [7:0] cost;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } match_t;

  typedef enum logic [1:0] {RK_PRED, RK_NONE, RK_RES, RK_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        m, l, r;
    logic [1:0]  addr;
    logic [10:0] data;
    match_t      x;
  } drow_t;

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [10:0] cfg_data;
  logic        in_valid, in_ready, mode, left_bit, right_bit;
  logic        out_valid, out_ready;
  logic [5:0]  disparity;
  logic [7:0]  best_cost;
  logic [9:0]  out_row, out_col;
  logic        last_of_frame;

  binary_window_disparity_search dut (.*);

  // predictor state
  bit     lstore [RING*bwds_pkg::MAX_WIDTH_D];
  bit     rstore [RING*bwds_pkg::MAX_WIDTH_D];
  int     raw_w, raw_h, raw_half, raw_disp;
  int     in_r, in_c, res_r, res_c;
  bit     frame_tail;
  match_t match_q[$];
  int     err_cnt;
  int     sent_cnt;
  int     burst_left, gap_left;
  int     idle_cnt;
  int     stall_sel;
  int     stall_cnt;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit px(bit is_left, int row, int col, int hh, int ww);
    if (row < 0 || row >= hh || col < 0 || col >= ww) return 0;
    return is_left ? lstore[(row % RING)*bwds_pkg::MAX_WIDTH_D + col]
                   : rstore[(row % RING)*bwds_pkg::MAX_WIDTH_D + col];
  endfunction

  function automatic bit next_match(output match_t o);
    int w, hg, h, d, area, best, dis, cost;
    longint got, nr, nc;
    w = clampi(raw_w, 1, bwds_pkg::MAX_WIDTH_D);
    hg = clampi(raw_h, 1, bwds_pkg::MAX_HEIGHT_D);
    h = clampi(raw_half, 1, bwds_pkg::MAX_HALF_D);
    d = clampi(raw_disp, 1, bwds_pkg::MAX_DISP_D);
    area = (2*h+1)*(2*h+1);
    best = area;
    dis = 0;
    o = '0;
    if (res_r >= hg || res_c >= w) begin
      frame_tail = 0;
      res_r = 0;
      res_c = 0;
      return 0;
    end
    if (!frame_tail) begin
      got = longint'(in_r)*w + in_c;
      nr = (res_r + h < hg - 1) ? res_r + h : hg - 1;
      nc = (res_c + h + d - 1 < w - 1) ? res_c + h + d - 1 : w - 1;
      if (nr*w + nc >= got) return 0;
    end
    for (int k = 0; k < d; k++) begin
      cost = 0;
      for (int dy = -h; dy <= h; dy++)
        for (int dx = -h; dx <= h; dx++)
          cost += int'(px(1, res_r+dy, res_c+dx, hg, w) != px(0, res_r+dy, res_c+dx+k, hg, w));
      if (cost < best) begin
        best = cost;
        dis = k;
      end
    end
    o.disp = dis[5:0];
    o.cost = best[7:0];
    o.row = res_r[9:0];
    o.col = res_c[9:0];
    o.last = (res_r == hg-1 && res_c == w-1);
    res_c++;
    if (res_c == w) begin
      res_c = 0;
      res_r++;
      if (res_r == hg) begin
        res_r = 0;
        frame_tail = 0;
      end
    end
    return 1;
  endfunction

  function automatic bit predict_transfer(logic m, logic l, logic r, output match_t o);
    int w, hg, at;
    w = clampi(raw_w, 1, bwds_pkg::MAX_WIDTH_D);
    hg = clampi(raw_h, 1, bwds_pkg::MAX_HEIGHT_D);
    o = '0;
    if (m == bwds_pkg::MODE_FLUSH) return frame_tail ? next_match(o) : 0;
    if (frame_tail) begin
      frame_tail = 0;
      res_r = 0;
      res_c = 0;
    end
    if (in_r >= hg || in_c >= w) begin
      in_r = 0; in_c = 0; res_r = 0; res_c = 0;
    end
    at = (in_r % RING)*bwds_pkg::MAX_WIDTH_D + in_c;
    lstore[at] = l;
    rstore[at] = r;
    in_c++;
    if (in_c == w) begin
      in_c = 0;
      in_r++;
      if (in_r == hg) begin
        in_r = 0;
        frame_tail = 1;
      end
    end
    return next_match(o);
  endfunction

  // one input transfer; the expected result is predicted, typed as none, or typed in
  task automatic send_pixel(logic m, logic l, logic r, row_kind_t kind = RK_PRED,
                            match_t tx = '0);
    match_t o;
    bit has;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 40));
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
    end
    while (gap_left > 0) begin
      in_valid <= 0;
      @(posedge clk);
      gap_left--;
    end
    in_valid <= 1;
    mode <= m;
    left_bit <= l;
    right_bit <= r;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_cnt++;
    has = predict_transfer(m, l, r, o);
    if (kind == RK_RES) match_q.push_back(tx);
    else if (kind == RK_PRED && has) match_q.push_back(o);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] a, logic [10:0] v);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (a)
      bwds_pkg::REG_WIDTH:  raw_w = int'(v);
      bwds_pkg::REG_HEIGHT: raw_h = int'(v);
      bwds_pkg::REG_HALF:   raw_half = int'(v[2:0]);
      bwds_pkg::REG_DISP:   raw_disp = int'(v[6:0]);
      default: ;
    endcase
  endtask

  task automatic drain_frame();
    while (frame_tail)
      send_pixel(bwds_pkg::MODE_FLUSH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      stall_sel <= 0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 300 == 0) stall_sel <= int'($urandom_range(0, 2));
      case (stall_sel)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    match_t e;
    if (!rst && out_valid && out_ready) begin
      if (match_q.size() == 0) begin
        $error("unexpected result row %0d col %0d", out_row, out_col);
        err_cnt++;
      end else begin
        e = match_q.pop_front();
        if (disparity !== e.disp) begin
          $error("disparity exp %0d got %0d", e.disp, disparity); err_cnt++;
        end
        if (best_cost !== e.cost) begin
          $error("best_cost exp %0d got %0d", e.cost, best_cost); err_cnt++;
        end
        if (out_row !== e.row) begin
          $error("out_row exp %0d got %0d", e.row, out_row); err_cnt++;
        end
        if (out_col !== e.col) begin
          $error("out_col exp %0d got %0d", e.col, out_col); err_cnt++;
        end
        if (last_of_frame !== e.last) begin
          $error("last_of_frame exp %0d got %0d", e.last, last_of_frame); err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    drow_t tbl[$];
    bit    lrow [bwds_pkg::MAX_WIDTH_D];
    int    w, hg, shift, nflush;
    bit    l, r;
    rst = 1; cfg_we = 0; cfg_addr = bwds_pkg::REG_WIDTH; cfg_data = '0;
    in_valid = 0; mode = bwds_pkg::MODE_PIXEL; left_bit = 0; right_bit = 0;
    err_cnt = 0; sent_cnt = 0; burst_left = 0; gap_left = 0;
    raw_w = int'(bwds_pkg::RST_WIDTH);
    raw_h = int'(bwds_pkg::RST_HEIGHT);
    raw_half = int'(bwds_pkg::RST_HALF);
    raw_disp = int'(bwds_pkg::RST_DISP);
    in_r = 0; in_c = 0; res_r = 0; res_c = 0; frame_tail = 0;

    tbl = '{
      '{RK_NONE, bwds_pkg::MODE_FLUSH, 1'b1, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_NONE, bwds_pkg::MODE_FLUSH, 1'b0, 1'b0, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_WIDTH, 11'd1, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_HEIGHT, 11'd0, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_HALF, 11'd0, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_DISP, 11'd0, '0},
      '{RK_RES, bwds_pkg::MODE_PIXEL, 1'b1, 1'b1, bwds_pkg::REG_WIDTH, 11'd0,
        '{6'd0, 8'd0, 10'd0, 10'd0, 1'b1}},
      '{RK_RES, bwds_pkg::MODE_PIXEL, 1'b1, 1'b0, bwds_pkg::REG_WIDTH, 11'd0,
        '{6'd0, 8'd1, 10'd0, 10'd0, 1'b1}},
      '{RK_RES, bwds_pkg::MODE_PIXEL, 1'b0, 1'b1, bwds_pkg::REG_WIDTH, 11'd0,
        '{6'd0, 8'd1, 10'd0, 10'd0, 1'b1}},
      '{RK_RES, bwds_pkg::MODE_PIXEL, 1'b0, 1'b0, bwds_pkg::REG_WIDTH, 11'd0,
        '{6'd0, 8'd0, 10'd0, 10'd0, 1'b1}},
      '{RK_NONE, bwds_pkg::MODE_FLUSH, 1'b1, 1'b0, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_WIDTH, 11'd3, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_HEIGHT, 11'd2, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_HALF, 11'd7, '0},
      '{RK_CFG, 1'b0, 1'b0, 1'b0, bwds_pkg::REG_DISP, 11'd127, '0},
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b1, 1'b0, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b0, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_FLUSH, 1'b1, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b1, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b1, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b0, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b1, 1'b0, bwds_pkg::REG_WIDTH, 11'd0, '0},
      '{RK_PRED, bwds_pkg::MODE_FLUSH, 1'b0, 1'b0, bwds_pkg::REG_WIDTH, 11'd0, '0},
      // new frame before drain discards the rest
      '{RK_PRED, bwds_pkg::MODE_PIXEL, 1'b1, 1'b1, bwds_pkg::REG_WIDTH, 11'd0, '0}
    };

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (tbl[i]) begin
      case (tbl[i].kind)
        RK_CFG:  begin
          wait_drained();
          write_reg(tbl[i].addr, tbl[i].data);
        end
        RK_NONE: send_pixel(tbl[i].m, tbl[i].l, tbl[i].r, RK_NONE);
        RK_RES:  send_pixel(tbl[i].m, tbl[i].l, tbl[i].r, RK_RES, tbl[i].x);
        default: send_pixel(tbl[i].m, tbl[i].l, tbl[i].r, RK_PRED);
      endcase
    end
    for (int i = 0; i < 5; i++)
      send_pixel(bwds_pkg::MODE_PIXEL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain_frame();

    // widest row, clamped from the largest register value
    wait_drained();
    write_reg(bwds_pkg::REG_WIDTH, 11'd2047);
    write_reg(bwds_pkg::REG_HEIGHT, 11'd1);
    write_reg(bwds_pkg::REG_HALF, 11'd1);
    write_reg(bwds_pkg::REG_DISP, 11'd2);
    for (int c = 0; c < 1024; c++)
      send_pixel(bwds_pkg::MODE_PIXEL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain_frame();

    while (sent_cnt < ITEMS) begin
      if (!frame_tail && $urandom_range(0, 2) != 0) begin
        wait_drained();
        if ($urandom_range(0, 9) == 0) begin
          write_reg(bwds_pkg::REG_WIDTH, 11'($urandom_range(1, 3)));
          write_reg(bwds_pkg::REG_HEIGHT, 11'($urandom_range(1, 2)));
          write_reg(bwds_pkg::REG_HALF, 11'($urandom_range(0, 1)));
          write_reg(bwds_pkg::REG_DISP, 11'($urandom_range(60, 127)));
        end else begin
          write_reg(bwds_pkg::REG_WIDTH, 11'($urandom_range(0, 12)));
          write_reg(bwds_pkg::REG_HEIGHT, 11'($urandom_range(0, 6)));
          write_reg(bwds_pkg::REG_HALF, 11'(($urandom_range(0, 5) == 0) ?
                                            $urandom_range(3, 4) : $urandom_range(0, 2)));
          write_reg(bwds_pkg::REG_DISP, 11'($urandom_range(0, 6)));
        end
      end
      w = clampi(raw_w, 1, bwds_pkg::MAX_WIDTH_D);
      hg = clampi(raw_h, 1, bwds_pkg::MAX_HEIGHT_D);
      shift = int'($urandom_range(0, 4));
      for (int rr = 0; rr < hg; rr++)
        for (int cc = 0; cc < w; cc++) begin
          if ($urandom_range(0, 15) == 0) send_pixel(bwds_pkg::MODE_FLUSH, 1'b1, 1'b1);
          l = 1'($urandom_range(0, 1));
          lrow[cc] = l;
          r = (cc >= shift && $urandom_range(0, 7) != 0) ? lrow[cc-shift]
                                                         : 1'($urandom_range(0, 1));
          send_pixel(bwds_pkg::MODE_PIXEL, l, r);
        end
      if ($urandom_range(0, 4) == 0) begin
        nflush = int'($urandom_range(0, w*hg));
        for (int i = 0; i < nflush; i++)
          send_pixel(bwds_pkg::MODE_FLUSH, 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        drain_frame();
        if ($urandom_range(0, 3) == 0) send_pixel(bwds_pkg::MODE_FLUSH, 1'b0, 1'b1);
      end
    end

    in_valid <= 0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/bwds_pkg.sv
rtl/bwds_ram.sv
rtl/binary_window_disparity_search.sv
tb/tb_binary_window_disparity_search.sv
